// File: hdl/hbcf_pkg.sv
// ----------------------------------------------------------------------------
// hbcf_pkg
// Shared types, constants and helpers of the HTTP body CRC flash streamer.
// ----------------------------------------------------------------------------
package hbcf_pkg;

  localparam int SECTOR_BYTES  = 4096;
  localparam int PAGE_BYTES    = 256;
  localparam int HEADER_BUFFER = 4096;

  localparam int ADDR_W   = 24;
  localparam int CRC_W    = 32;
  localparam int HDR_W    = $clog2(HEADER_BUFFER);
  localparam int SECTOR_W = $clog2(SECTOR_BYTES);
  localparam int PAGE_W   = $clog2(PAGE_BYTES);
  localparam int CFG_IDX_W = 2;

  localparam logic [CRC_W-1:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam int PREFIX_LEN = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LEN = 2'd1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_BODY   = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    ST_STARTED    = 4'd0,
    ST_IGNORED    = 4'd1,
    ST_HEADER     = 4'd2,
    ST_BODY       = 4'd3,
    ST_DONE_OK    = 4'd4,
    ST_BAD_RESP   = 4'd5,
    ST_HDR_OVFL   = 4'd6,
    ST_SIZE_MISM  = 4'd7,
    ST_TOO_LARGE  = 4'd8
  } status_e;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] flash_address;
    logic              erase_sector;
    logic              page_start;
    logic [ADDR_W-1:0] body_length;
    logic [CRC_W-1:0]  crc_value;
  } res_t;

  // Expected character of the status line prefix "HTTP/1."
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h48;  // H
      3'd1:    ch = 8'h54;  // T
      3'd2:    ch = 8'h54;  // T
      3'd3:    ch = 8'h50;  // P
      3'd4:    ch = 8'h2F;  // /
      3'd5:    ch = 8'h31;  // 1
      default: ch = 8'h2E;  // .
    endcase
    return ch;
  endfunction

endpackage

// File: hdl/hbcf_crc32.sv
// ----------------------------------------------------------------------------
// hbcf_crc32
// Byte-wide reflected CRC-32 update on the finalized CRC value.
// ----------------------------------------------------------------------------
module hbcf_crc32
  import hbcf_pkg::*;
(
  input  logic [CRC_W-1:0] crc_i,
  input  logic [7:0]       data_i,
  output logic [CRC_W-1:0] crc_o
);

  logic [CRC_W-1:0] c;

  always_comb begin
    c = crc_i ^ CRC_ALL_ONES;
    c = c ^ {{(CRC_W-8){1'b0}}, data_i};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
    end
    crc_o = c ^ CRC_ALL_ONES;
  end

endmodule

// File: hdl/hbcf_engine.sv
// ----------------------------------------------------------------------------
// hbcf_engine
// Download state and the combinational step for a single command.
// ----------------------------------------------------------------------------
module hbcf_engine
  import hbcf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [1:0]        command_i,
  input  logic [7:0]        data_byte_i,
  input  logic [ADDR_W-1:0] flash_base_i,
  input  logic [ADDR_W-1:0] expected_length_i,
  output res_t              res_o
);

  mode_e             mode_q, mode_d;
  logic [HDR_W-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [1:0]        term_q, term_d;
  logic              prefix_ok_q, prefix_ok_d;
  logic [ADDR_W-1:0] body_cnt_q, body_cnt_d;
  logic [CRC_W-1:0]  crc_q, crc_d;

  logic [CRC_W-1:0]  crc_next;
  logic [HDR_W:0]    hdr_inc;
  logic              found;

  hbcf_crc32 u_crc (
    .crc_i  (crc_q),
    .data_i (data_byte_i),
    .crc_o  (crc_next)
  );

  always_comb begin
    mode_d      = mode_q;
    hdr_cnt_d   = hdr_cnt_q;
    term_d      = term_q;
    prefix_ok_d = prefix_ok_q;
    body_cnt_d  = body_cnt_q;
    crc_d       = crc_q;
    found       = 1'b0;
    hdr_inc     = {1'b0, hdr_cnt_q} + (HDR_W+1)'(1);

    res_o.status        = ST_IGNORED;
    res_o.flash_address = '0;
    res_o.erase_sector  = 1'b0;
    res_o.page_start    = 1'b0;

    unique case (command_i)
      CMD_START: begin
        mode_d      = MODE_HEADER;
        hdr_cnt_d   = '0;
        term_d      = '0;
        prefix_ok_d = 1'b1;
        body_cnt_d  = '0;
        crc_d       = '0;
        res_o.status = ST_STARTED;
      end
      CMD_BYTE: begin
        if (mode_q == MODE_HEADER) begin
          if (hdr_cnt_q < HDR_W'(PREFIX_LEN) &&
              data_byte_i != prefix_char(hdr_cnt_q[2:0])) begin
            prefix_ok_d = 1'b0;
          end
          hdr_cnt_d = hdr_inc[HDR_W-1:0];
          if (term_q == 2'd3 && data_byte_i == CHAR_LF) begin
            found = 1'b1;
          end else if ((term_q == 2'd0 || term_q == 2'd2) && data_byte_i == CHAR_CR) begin
            term_d = term_q + 2'd1;
          end else if (term_q == 2'd1 && data_byte_i == CHAR_LF) begin
            term_d = 2'd2;
          end else begin
            term_d = (data_byte_i == CHAR_CR) ? 2'd1 : 2'd0;
          end
          if (found) begin
            term_d = '0;
            if (prefix_ok_d) begin
              mode_d       = MODE_BODY;
              res_o.status = ST_HEADER;
            end else begin
              mode_d       = MODE_IDLE;
              res_o.status = ST_BAD_RESP;
            end
          end else if (hdr_inc >= (HDR_W+1)'(HEADER_BUFFER - 1)) begin
            mode_d       = MODE_IDLE;
            res_o.status = ST_HDR_OVFL;
          end else begin
            res_o.status = ST_HEADER;
          end
        end else if (mode_q == MODE_BODY) begin
          if (&body_cnt_q) begin
            mode_d       = MODE_IDLE;
            res_o.status = ST_TOO_LARGE;
          end else begin
            res_o.flash_address = flash_base_i + body_cnt_q;
            res_o.erase_sector  = (body_cnt_q[SECTOR_W-1:0] == '0);
            res_o.page_start    = (body_cnt_q[PAGE_W-1:0] == '0);
            crc_d               = crc_next;
            body_cnt_d          = body_cnt_q + ADDR_W'(1);
            res_o.status        = ST_BODY;
          end
        end
      end
      CMD_CLOSE: begin
        if (mode_q == MODE_HEADER) begin
          mode_d       = MODE_IDLE;
          res_o.status = ST_BAD_RESP;
        end else if (mode_q == MODE_BODY) begin
          mode_d       = MODE_IDLE;
          res_o.status = (expected_length_i != '0 && body_cnt_q != expected_length_i) ?
                         ST_SIZE_MISM : ST_DONE_OK;
        end
      end
      default: begin
        res_o.status = ST_IGNORED;
      end
    endcase

    res_o.body_length = body_cnt_d;
    res_o.crc_value   = crc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      hdr_cnt_q   <= '0;
      term_q      <= '0;
      prefix_ok_q <= 1'b1;
      body_cnt_q  <= '0;
      crc_q       <= '0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      hdr_cnt_q   <= hdr_cnt_d;
      term_q      <= term_d;
      prefix_ok_q <= prefix_ok_d;
      body_cnt_q  <= body_cnt_d;
      crc_q       <= crc_d;
    end
  end

endmodule

// File: hdl/http_body_crc_flash_streamer_top.sv
// ----------------------------------------------------------------------------
// http_body_crc_flash_streamer_top
// HTTP response body extractor with CRC-32 and flash address generation.
// ----------------------------------------------------------------------------
// Feed one transaction per received response byte (command 1), framed by a
// start transaction (command 0) and a connection-closed transaction
// (command 2); every input transaction yields exactly one result transaction.
// The header must begin with "HTTP/1." and end in CR LF CR LF; body bytes
// come back with their flash address (flash_base plus body offset), a sector
// erase mark on every SECTOR_BYTES boundary, a page mark on every PAGE_BYTES
// boundary, the running body length and the finalized CRC-32 so far. The
// block takes one transaction per clock while results are taken. An accepted
// command sits in the input register while the step logic (byte CRC update,
// counters and header matcher) computes its result, which loads the result
// register once the result slot is free or being drained. A result that is
// not taken holds the input register, and a full input register behind it
// holds in_ready_o low. Program flash_base and expected_length through the
// cfg port while no transaction is in flight.
// ----------------------------------------------------------------------------
module http_body_crc_flash_streamer_top
  import hbcf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           command_i,
  input  logic [7:0]           data_byte_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           status_o,
  output logic [ADDR_W-1:0]    flash_address_o,
  output logic                 erase_sector_o,
  output logic                 page_start_o,
  output logic [ADDR_W-1:0]    body_length_o,
  output logic [CRC_W-1:0]     crc_value_o
);

  // Configuration registers
  logic [ADDR_W-1:0] flash_base_q;
  logic [ADDR_W-1:0] exp_len_q;

  // Input register stage
  logic       s1_valid_q;
  logic [1:0] s1_cmd_q;
  logic [7:0] s1_byte_q;

  // Result register
  logic out_valid_q;
  res_t res_d, res_q;

  logic advance;

  // Step the engine when a command is held and the result slot is free or
  // being drained this cycle.
  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_base_q <= '0;
      exp_len_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      // Drop writes to indexes beyond the register list.
      if (cfg_index_i == CFG_FLASH_BASE) begin
        flash_base_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_EXPECTED_LEN) begin
        exp_len_q <= cfg_data_i;
      end
    end
  end

  // Capture a new command whenever the input register is empty or advancing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_cmd_q  <= command_i;
      s1_byte_q <= data_byte_i;
    end
  end

  hbcf_engine u_engine (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (advance),
    .command_i         (s1_cmd_q),
    .data_byte_i       (s1_byte_q),
    .flash_base_i      (flash_base_q),
    .expected_length_i (exp_len_q),
    .res_o             (res_d)
  );

  // Hold the result until the consumer takes it; load a fresh one on advance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign flash_address_o = res_q.flash_address;
  assign erase_sector_o  = res_q.erase_sector;
  assign page_start_o    = res_q.page_start;
  assign body_length_o   = res_q.body_length;
  assign crc_value_o     = res_q.crc_value;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Input stalls only when both stages are full and the output is blocked.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full, blocked pipeline");

  // Flash marks and addresses appear only on body byte results.
  a_marks_body_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_BODY) |->
      (flash_address_o == '0 && !erase_sector_o && !page_start_o))
    else $error("flash fields set on a non-body result");

  // A body byte result always counts at least that byte.
  a_body_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_BODY) |-> (body_length_o != '0))
    else $error("body byte reported with zero body length");

  // A start result reports an empty body and the CRC of no bytes.
  a_start_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_STARTED) |->
      (body_length_o == '0 && crc_value_o == '0))
    else $error("start result with nonzero length or CRC");

endmodule
